>>> hw/rtl/hmc_pkg.sv
// ----------------------------------------------------------------------------
// hmc_pkg
// Shared types, codes and defaults for the hysteresis mode controller.
// ----------------------------------------------------------------------------
package hmc_pkg;

	// field widths of the channel payloads and registers
	localparam int FIELD_W = 16;
	localparam int CFG_IDX_W = 3;

	// parameter defaults
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int CONF_WIDTH_DEF = 16;

	// register reset values
	localparam logic [FIELD_W-1:0] THR_ON_RST = 16'd45875;
	localparam logic [FIELD_W-1:0] THR_OFF_RST = 16'd26214;
	localparam logic [FIELD_W-1:0] ON_RUNS_RST = 16'd3;
	localparam logic [FIELD_W-1:0] OFF_RUNS_RST = 16'd3;
	localparam logic [FIELD_W-1:0] GRACE_RST = 16'd0;

	typedef enum logic [1:0] {
		MODE_DISABLED = 2'd0,
		MODE_OBSERVING = 2'd1,
		MODE_ACTIVE = 2'd2,
		MODE_RECOVERY = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD_ON = 3'd0,
		REG_THRESHOLD_OFF = 3'd1,
		REG_ON_RUNS = 3'd2,
		REG_OFF_RUNS = 3'd3,
		REG_GRACE = 3'd4
	} cfg_idx_t;

	// settings as the decision logic uses them: masked, ordered, run counts at least one
	typedef struct packed {
		logic [FIELD_W-1:0] thr_on;
		logic [FIELD_W-1:0] thr_off;
		logic [FIELD_W-1:0] on_runs;
		logic [FIELD_W-1:0] off_runs;
		logic [FIELD_W-1:0] grace;
	} cfg_t;

	typedef struct packed {
		logic enable_flag;
		logic recovery_request;
		logic recovery_done;
		logic eligible_flag;
		logic route_ok;
		logic [FIELD_W-1:0] confidence_level;
	} epoch_t;

	typedef struct packed {
		mode_t mode_now;
		logic mode_changed_flag;
		logic activated_flag;
		logic deactivated_flag;
		logic entered_recovery_flag;
		logic exited_recovery_flag;
		logic [FIELD_W-1:0] strong_run_out;
		logic [FIELD_W-1:0] weak_run_out;
		logic [FIELD_W-1:0] active_count_out;
	} result_t;

endpackage

>>> hw/rtl/hmc_if.sv
// ----------------------------------------------------------------------------
// hmc_if
// Valid/ready channels for epoch items and result items.
// ----------------------------------------------------------------------------
interface hmc_epoch_if;
	logic valid;
	logic ready;
	logic enable_flag;
	logic recovery_request;
	logic recovery_done;
	logic eligible_flag;
	logic route_ok;
	logic [hmc_pkg::FIELD_W-1:0] confidence_level;

	modport source (
		output valid, enable_flag, recovery_request, recovery_done, eligible_flag,
			route_ok, confidence_level,
		input ready
	);
	modport sink (
		input valid, enable_flag, recovery_request, recovery_done, eligible_flag,
			route_ok, confidence_level,
		output ready
	);
endinterface

interface hmc_result_if;
	logic valid;
	logic ready;
	logic [1:0] mode_now;
	logic mode_changed_flag;
	logic activated_flag;
	logic deactivated_flag;
	logic entered_recovery_flag;
	logic exited_recovery_flag;
	logic [hmc_pkg::FIELD_W-1:0] strong_run_out;
	logic [hmc_pkg::FIELD_W-1:0] weak_run_out;
	logic [hmc_pkg::FIELD_W-1:0] active_count_out;

	modport source (
		output valid, mode_now, mode_changed_flag, activated_flag, deactivated_flag,
			entered_recovery_flag, exited_recovery_flag, strong_run_out, weak_run_out,
			active_count_out,
		input ready
	);
	modport sink (
		input valid, mode_now, mode_changed_flag, activated_flag, deactivated_flag,
			entered_recovery_flag, exited_recovery_flag, strong_run_out, weak_run_out,
			active_count_out,
		output ready
	);
	modport monitor (
		input valid, ready, mode_now, mode_changed_flag, activated_flag,
			deactivated_flag, entered_recovery_flag, exited_recovery_flag,
			strong_run_out, weak_run_out, active_count_out
	);
endinterface

>>> hw/rtl/hysteresis_mode_controller_top.sv
// ----------------------------------------------------------------------------
// hysteresis_mode_controller_top
// Per-epoch four-mode controller with hysteresis on a confidence level.
//
//   channel  dir  handshake     carries
//   epoch    in   valid/ready   control flags and confidence of one epoch
//   result   out  valid/ready   mode, transition flags and run counters
//   cfg      in   cfg_write     register index and data, no read-back
//
// One epoch per clock sustained while results are taken; an accepted epoch
// passes the input register, then the decision logic into the result
// register, which offers it. The mode and counter state updates as the
// result is registered.
// A stalled result holds in its register while the input register still
// fills; the input side stops only when both are occupied.
// Asynchronous active-low reset clears mode and counters, loads the default
// registers, and empties both stages.
// ----------------------------------------------------------------------------
module hysteresis_mode_controller_top #(
	parameter int COUNT_WIDTH = hmc_pkg::COUNT_WIDTH_DEF,
	parameter int CONF_WIDTH = hmc_pkg::CONF_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic [hmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hmc_pkg::FIELD_W-1:0] cfg_data,
	hmc_epoch_if.sink epoch,
	hmc_result_if.source result
);

	hmc_pkg::cfg_t cfg;
	hmc_pkg::epoch_t epoch_s1;
	hmc_pkg::result_t res_comb;
	hmc_pkg::result_t res_q;
	logic valid_s1;
	logic res_valid_q;
	logic advance;

	// the first stage moves on whenever the result register is free or drains
	assign advance = valid_s1 && (!res_valid_q || result.ready);
	assign epoch.ready = !valid_s1 || advance;

	hmc_cfg #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.CONF_WIDTH(CONF_WIDTH)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (epoch.ready) begin
			valid_s1 <= epoch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (epoch.valid && epoch.ready) begin
			epoch_s1.enable_flag <= epoch.enable_flag;
			epoch_s1.recovery_request <= epoch.recovery_request;
			epoch_s1.recovery_done <= epoch.recovery_done;
			epoch_s1.eligible_flag <= epoch.eligible_flag;
			epoch_s1.route_ok <= epoch.route_ok;
			epoch_s1.confidence_level <= epoch.confidence_level;
		end
	end

	hmc_core #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.CONF_WIDTH(CONF_WIDTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.epoch(epoch_s1),
		.cfg(cfg),
		.result(res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || result.ready) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_comb;
		end
	end

	assign result.valid = res_valid_q;
	assign result.mode_now = res_q.mode_now;
	assign result.mode_changed_flag = res_q.mode_changed_flag;
	assign result.activated_flag = res_q.activated_flag;
	assign result.deactivated_flag = res_q.deactivated_flag;
	assign result.entered_recovery_flag = res_q.entered_recovery_flag;
	assign result.exited_recovery_flag = res_q.exited_recovery_flag;
	assign result.strong_run_out = res_q.strong_run_out;
	assign result.weak_run_out = res_q.weak_run_out;
	assign result.active_count_out = res_q.active_count_out;

endmodule

>>> hw/rtl/hmc_cfg.sv
// ----------------------------------------------------------------------------
// hmc_cfg
// Configuration registers and their normalization for the decision logic.
// ----------------------------------------------------------------------------
module hmc_cfg #(
	parameter int COUNT_WIDTH = hmc_pkg::COUNT_WIDTH_DEF,
	parameter int CONF_WIDTH = hmc_pkg::CONF_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic [hmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hmc_pkg::FIELD_W-1:0] cfg_data,
	output hmc_pkg::cfg_t cfg
);

	localparam int FW = hmc_pkg::FIELD_W;
	localparam int CONF_BITS = (CONF_WIDTH < FW) ? CONF_WIDTH : FW;
	localparam int CNT_BITS = (COUNT_WIDTH < FW) ? COUNT_WIDTH : FW;
	localparam logic [FW-1:0] CONF_MASK = FW'((33'd1 << CONF_BITS) - 33'd1);
	localparam logic [FW-1:0] CNT_MASK = FW'((33'd1 << CNT_BITS) - 33'd1);

	logic [FW-1:0] thr_on_q;
	logic [FW-1:0] thr_off_q;
	logic [FW-1:0] on_runs_q;
	logic [FW-1:0] off_runs_q;
	logic [FW-1:0] grace_q;

	logic [FW-1:0] on_m;
	logic [FW-1:0] off_m;
	logic [FW-1:0] on_runs_m;
	logic [FW-1:0] off_runs_m;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_on_q <= hmc_pkg::THR_ON_RST;
			thr_off_q <= hmc_pkg::THR_OFF_RST;
			on_runs_q <= hmc_pkg::ON_RUNS_RST;
			off_runs_q <= hmc_pkg::OFF_RUNS_RST;
			grace_q <= hmc_pkg::GRACE_RST;
		end else if (cfg_write) begin
			unique case (hmc_pkg::cfg_idx_t'(cfg_index))
				hmc_pkg::REG_THRESHOLD_ON: thr_on_q <= cfg_data;
				hmc_pkg::REG_THRESHOLD_OFF: thr_off_q <= cfg_data;
				hmc_pkg::REG_ON_RUNS: on_runs_q <= cfg_data;
				hmc_pkg::REG_OFF_RUNS: off_runs_q <= cfg_data;
				hmc_pkg::REG_GRACE: grace_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// mask to the working widths, order the thresholds, zero persistence as one
	always_comb begin
		on_m = thr_on_q & CONF_MASK;
		off_m = thr_off_q & CONF_MASK;
		on_runs_m = on_runs_q & CNT_MASK;
		off_runs_m = off_runs_q & CNT_MASK;
		if (on_m < off_m) begin
			cfg.thr_on = off_m;
			cfg.thr_off = on_m;
		end else begin
			cfg.thr_on = on_m;
			cfg.thr_off = off_m;
		end
		cfg.on_runs = (on_runs_m == '0) ? FW'(1) : on_runs_m;
		cfg.off_runs = (off_runs_m == '0) ? FW'(1) : off_runs_m;
		cfg.grace = grace_q & CNT_MASK;
	end

endmodule

>>> hw/rtl/hmc_core.sv
// ----------------------------------------------------------------------------
// hmc_core
// Mode and run counter state with the per-epoch decision logic.
// ----------------------------------------------------------------------------
module hmc_core #(
	parameter int COUNT_WIDTH = hmc_pkg::COUNT_WIDTH_DEF,
	parameter int CONF_WIDTH = hmc_pkg::CONF_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  hmc_pkg::epoch_t epoch,
	input  hmc_pkg::cfg_t cfg,
	output hmc_pkg::result_t result
);

	localparam int FW = hmc_pkg::FIELD_W;
	localparam int CONF_BITS = (CONF_WIDTH < FW) ? CONF_WIDTH : FW;

	hmc_pkg::mode_t mode_q;
	hmc_pkg::mode_t mode_n;
	logic [COUNT_WIDTH-1:0] strong_q, weak_q, act_q;
	logic [COUNT_WIDTH-1:0] strong_n, weak_n, act_n;
	logic [COUNT_WIDTH-1:0] strong_base, strong_inc, weak_inc, act_inc;
	logic [COUNT_WIDTH-1:0] on_p, off_p, grace;
	logic [FW-1:0] conf;
	logic strong_hit, weak_hit;
	logic act, deact, ent, ext;

	// saturating increment
	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (&v) ? v : v + COUNT_WIDTH'(1);
	endfunction

	assign conf = FW'(epoch.confidence_level[CONF_BITS-1:0]);
	assign strong_hit = conf >= cfg.thr_on;
	assign weak_hit = conf <= cfg.thr_off;
	assign on_p = COUNT_WIDTH'(cfg.on_runs);
	assign off_p = COUNT_WIDTH'(cfg.off_runs);
	assign grace = COUNT_WIDTH'(cfg.grace);

	// coming from disabled the strong run starts from zero
	assign strong_base = (mode_q == hmc_pkg::MODE_DISABLED) ? '0 : strong_q;
	assign strong_inc = strong_hit ? sat_inc(strong_base) : '0;
	assign act_inc = sat_inc(act_q);
	assign weak_inc = weak_hit ? sat_inc(weak_q) : '0;

	// decision for one epoch, in priority order
	always_comb begin
		mode_n = mode_q;
		strong_n = '0;
		weak_n = '0;
		act_n = '0;
		act = 1'b0;
		deact = 1'b0;
		ent = 1'b0;
		ext = 1'b0;
		if (!epoch.enable_flag) begin
			deact = (mode_q == hmc_pkg::MODE_ACTIVE);
			mode_n = hmc_pkg::MODE_DISABLED;
		end else if (epoch.recovery_request) begin
			deact = (mode_q == hmc_pkg::MODE_ACTIVE);
			ent = (mode_q != hmc_pkg::MODE_RECOVERY);
			mode_n = hmc_pkg::MODE_RECOVERY;
		end else if (mode_q == hmc_pkg::MODE_RECOVERY) begin
			if (epoch.recovery_done) begin
				ext = 1'b1;
				mode_n = epoch.eligible_flag ? hmc_pkg::MODE_OBSERVING
					: hmc_pkg::MODE_DISABLED;
			end
		end else if (!epoch.eligible_flag) begin
			deact = (mode_q == hmc_pkg::MODE_ACTIVE);
			mode_n = hmc_pkg::MODE_DISABLED;
		end else if (mode_q == hmc_pkg::MODE_ACTIVE) begin
			// active: count epochs and weak run, fall back after grace
			if (act_inc >= grace && weak_inc >= off_p) begin
				mode_n = hmc_pkg::MODE_OBSERVING;
				deact = 1'b1;
			end else begin
				act_n = act_inc;
				weak_n = weak_inc;
			end
		end else begin
			// observing, also entered from disabled this epoch
			if (strong_inc >= on_p && epoch.route_ok) begin
				mode_n = hmc_pkg::MODE_ACTIVE;
				act = 1'b1;
			end else begin
				mode_n = hmc_pkg::MODE_OBSERVING;
				strong_n = strong_inc;
			end
		end
	end

	// state advances once per processed epoch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= hmc_pkg::MODE_DISABLED;
			strong_q <= '0;
			weak_q <= '0;
			act_q <= '0;
		end else if (step) begin
			mode_q <= mode_n;
			strong_q <= strong_n;
			weak_q <= weak_n;
			act_q <= act_n;
		end
	end

	always_comb begin
		result.mode_now = mode_n;
		result.mode_changed_flag = (mode_n != mode_q);
		result.activated_flag = act;
		result.deactivated_flag = deact;
		result.entered_recovery_flag = ent;
		result.exited_recovery_flag = ext;
		result.strong_run_out = FW'(strong_n);
		result.weak_run_out = FW'(weak_n);
		result.active_count_out = FW'(act_n);
	end

endmodule

>>> hw/rtl/hmc_checker.sv
// ----------------------------------------------------------------------------
// hmc_checker
// Port-level checks on the result channel of the mode controller.
// ----------------------------------------------------------------------------
module hmc_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic [1:0] mode_now,
	input logic mode_changed_flag,
	input logic activated_flag,
	input logic deactivated_flag,
	input logic entered_recovery_flag,
	input logic exited_recovery_flag,
	input logic [hmc_pkg::FIELD_W-1:0] strong_run_out,
	input logic [hmc_pkg::FIELD_W-1:0] weak_run_out,
	input logic [hmc_pkg::FIELD_W-1:0] active_count_out
);

	// a waiting result is not withdrawn
	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn while stalled");

	// activation lands in active mode with counters cleared
	a_activate: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && activated_flag |->
			mode_now == 2'(hmc_pkg::MODE_ACTIVE) && mode_changed_flag &&
			strong_run_out == '0 && weak_run_out == '0 &&
			active_count_out == '0)
		else $error("activation without active mode or clear counters");

	// deactivation always leaves active mode
	a_deactivate: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && deactivated_flag |->
			mode_now != 2'(hmc_pkg::MODE_ACTIVE) && mode_changed_flag &&
			!activated_flag)
		else $error("deactivation while still active");

	// recovery entry lands in recovery and never pairs with an exit
	a_recovery: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && entered_recovery_flag |->
			mode_now == 2'(hmc_pkg::MODE_RECOVERY) && !exited_recovery_flag)
		else $error("recovery entry inconsistent");

	// outside active mode the active count is zero, outside observing the strong run is
	a_counters: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |->
			(mode_now == 2'(hmc_pkg::MODE_ACTIVE) || active_count_out == '0) &&
			(mode_now == 2'(hmc_pkg::MODE_OBSERVING) || strong_run_out == '0))
		else $error("counter running in wrong mode");

endmodule

bind hysteresis_mode_controller_top hmc_checker u_hmc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.mode_now(result.mode_now),
	.mode_changed_flag(result.mode_changed_flag),
	.activated_flag(result.activated_flag),
	.deactivated_flag(result.deactivated_flag),
	.entered_recovery_flag(result.entered_recovery_flag),
	.exited_recovery_flag(result.exited_recovery_flag),
	.strong_run_out(result.strong_run_out),
	.weak_run_out(result.weak_run_out),
	.active_count_out(result.active_count_out)
);
